FILE: sv/atfb_pkg.sv
// ============================================================================
// atfb_pkg
// Shared types and constants for the transmit-request frame builder.
// ============================================================================
package atfb_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_BODY,
        S_CSUM
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_API_ID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS     = 3'd4;

    localparam logic [2:0] HDR_DELIM   = 3'd0;
    localparam logic [2:0] HDR_LEN_HI  = 3'd1;
    localparam logic [2:0] HDR_LEN_LO  = 3'd2;
    localparam logic [2:0] HDR_API_ID  = 3'd3;
    localparam logic [2:0] HDR_FRAME   = 3'd4;
    localparam logic [2:0] HDR_DEST_HI = 3'd5;
    localparam logic [2:0] HDR_DEST_LO = 3'd6;
    localparam logic [2:0] HDR_OPTIONS = 3'd7;

    localparam logic [7:0] LEN_HI_BYTE  = 8'h00;
    localparam logic [7:0] LEN_OVERHEAD = 8'd5;
    localparam logic [7:0] CSUM_BASE    = 8'hFF;

    localparam logic [7:0] RST_START_DELIM = 8'h7E;
    localparam logic [7:0] RST_API_ID      = 8'h01;
    localparam logic [7:0] RST_FRAME_NUM   = 8'h00;
    localparam logic [15:0] RST_DEST_ADDR  = 16'hFFFF;
    localparam logic [7:0] RST_OPTIONS     = 8'h00;

endpackage

FILE: sv/api_tx_frame_builder_unit.sv
// Start: the end-marked byte moves the state to the header state; the first frame
//   byte is then registered into the output register once that register is free.
// Throughput: one payload byte per cycle into the buffer while idle; a frame of N
//   payload bytes (N + 9 output bytes) has a gap before the payload and one before
//   the checksum. No input is accepted meanwhile.
// Reset: synchronous, active low; clears state, count, sum, drop flag, output valid.
// ============================================================================
// api_tx_frame_builder_unit
// Buffers message bytes and emits a transmit-request frame with an additive
// checksum when the end-of-message byte arrives.
// ============================================================================
module api_tx_frame_builder_unit
    import atfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_message,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_frame_byte,
    output logic                  o_frame_end,
    output logic                  o_overflow
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    logic [7:0]  r_mem [MAX_PAYLOAD];
    logic [7:0]  r_mem_q;

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]  r_sum, n_sum;
    logic        r_drop, n_drop;
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic        r_q_valid, n_q_valid;

    logic [7:0]  r_start_delim, r_api_id, r_frame_num, r_options;
    logic [15:0] r_dest_addr;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;
    logic        r_out_ovf;

    logic        w_load;
    logic        w_in_fire;
    logic        w_push;
    logic [7:0]  w_push_byte;
    logic        w_push_end;
    logic        w_rd_en;
    logic        w_consume;
    logic        w_body_done;
    logic [7:0]  w_hdr_byte;
    logic [7:0]  w_frame_sum;

    assign w_load      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign w_frame_sum = r_sum + r_api_id + r_frame_num + r_dest_addr[15:8]
                       + r_dest_addr[7:0] + r_options;
    assign w_body_done = (r_rd_idx == r_count) && !r_q_valid;

    always_comb begin
        unique case (r_hdr_idx)
            HDR_DELIM:   w_hdr_byte = r_start_delim;
            HDR_LEN_HI:  w_hdr_byte = LEN_HI_BYTE;
            HDR_LEN_LO:  w_hdr_byte = 8'(r_count) + LEN_OVERHEAD;
            HDR_API_ID:  w_hdr_byte = r_api_id;
            HDR_FRAME:   w_hdr_byte = r_frame_num;
            HDR_DEST_HI: w_hdr_byte = r_dest_addr[15:8];
            HDR_DEST_LO: w_hdr_byte = r_dest_addr[7:0];
            HDR_OPTIONS: w_hdr_byte = r_options;
            default:     w_hdr_byte = r_start_delim;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && i_end_of_message) n_state = S_HEAD;
            end
            S_HEAD: begin
                if (w_load && r_hdr_idx == HDR_OPTIONS) n_state = S_BODY;
            end
            S_BODY: begin
                if (w_body_done) n_state = S_CSUM;
            end
            S_CSUM: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_drop      = r_drop;
        n_hdr_idx   = r_hdr_idx;
        n_rd_idx    = r_rd_idx;
        n_q_valid   = r_q_valid;
        w_push      = 1'b0;
        w_push_byte = r_mem_q;
        w_push_end  = 1'b0;
        w_rd_en     = 1'b0;
        w_consume   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_hdr_idx = HDR_DELIM;
                n_rd_idx  = '0;
                n_q_valid = 1'b0;
                if (w_in_fire) begin
                    if (r_count < CNT_MAX) begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + i_data_byte;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end
            S_HEAD: begin
                w_push      = w_load;
                w_push_byte = w_hdr_byte;
                if (w_load) n_hdr_idx = r_hdr_idx + 1'b1;
            end
            S_BODY: begin
                w_consume   = r_q_valid && w_load;
                w_push      = w_consume;
                w_push_byte = r_mem_q;
                w_rd_en     = (r_rd_idx != r_count) && (!r_q_valid || w_load);
                if (w_rd_en) n_rd_idx = r_rd_idx + 1'b1;
                if (w_rd_en) begin
                    n_q_valid = 1'b1;
                end else if (w_consume) begin
                    n_q_valid = 1'b0;
                end
            end
            S_CSUM: begin
                w_push      = w_load;
                w_push_byte = CSUM_BASE - w_frame_sum;
                w_push_end  = 1'b1;
                if (w_load) begin
                    n_count = '0;
                    n_sum   = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_q_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_drop      <= 1'b0;
            r_hdr_idx   <= HDR_DELIM;
            r_rd_idx    <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_drop    <= n_drop;
            r_hdr_idx <= n_hdr_idx;
            r_rd_idx  <= n_rd_idx;
            r_q_valid <= n_q_valid;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_byte <= w_push_byte;
            r_out_end  <= w_push_end;
            r_out_ovf  <= r_drop;
        end
    end

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (w_in_fire && r_count < CNT_MAX) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_data_byte;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[r_rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= RST_START_DELIM;
            r_api_id      <= RST_API_ID;
            r_frame_num   <= RST_FRAME_NUM;
            r_dest_addr   <= RST_DEST_ADDR;
            r_options     <= RST_OPTIONS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_DELIM: r_start_delim <= i_cfg_data[7:0];
                CFG_API_ID:      r_api_id      <= i_cfg_data[7:0];
                CFG_FRAME_NUM:   r_frame_num   <= i_cfg_data[7:0];
                CFG_DEST_ADDR:   r_dest_addr   <= i_cfg_data;
                CFG_OPTIONS:     r_options     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;
    assign o_overflow   = r_out_ovf;

endmodule

FILE: sv/atfb_checker.sv
// ============================================================================
// atfb_checker
// Port-level checks on the frame builder, bound to the top level.
// ============================================================================
module atfb_checker
    import atfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_end_of_message,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_frame_end,
    input logic       o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_eom_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_message |=> !o_in_ready)
        else $error("input accepted right after end of message");

    a_no_input_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> !o_in_ready)
        else $error("input ready while a frame is in flight");

    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_frame_end
        |=> !o_out_valid || (o_overflow == $past(o_overflow)))
        else $error("overflow flag changed within a frame");

endmodule

bind api_tx_frame_builder_unit atfb_checker u_atfb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_end_of_message (i_end_of_message),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_frame_end      (o_frame_end),
    .o_overflow       (o_overflow)
);

FILE: bench/tb_api_tx_frame_builder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_api_tx_frame_builder_unit
// Self-checking bench for the transmit-request frame builder. Message bytes
// are sent over a valid/ready channel. A built-in model buffers them and
// forms the expected frame bytes in order: header, payload, additive
// checksum, and the overflow flag. Every output transfer is checked against
// that model. Register settings change between phases, and one change falls
// in the middle of a message. The sender and receiver idle at random.
// ============================================================================
module tb_api_tx_frame_builder_unit;
    import atfb_pkg::*;

    localparam int PAYLOAD_CAP    = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASE_ITEMS    = 80;

    typedef struct {
        logic [7:0] data_byte;
        logic       end_mark;
        bit         wait_drain;
    } t_msg_byte;

    typedef struct {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       overflow;
    } t_frame_byte;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte      = '0;
    logic                  i_end_of_message = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [7:0]            o_frame_byte;
    logic                  o_frame_end;
    logic                  o_overflow;

    t_msg_byte   msg_bytes_pending[$];
    t_frame_byte frame_bytes_due[$];

    logic [7:0]  reg_delim     = RST_START_DELIM;
    logic [7:0]  reg_api_id    = RST_API_ID;
    logic [7:0]  reg_frame_num = RST_FRAME_NUM;
    logic [15:0] reg_dest      = RST_DEST_ADDR;
    logic [7:0]  reg_options   = RST_OPTIONS;

    logic [7:0]  msg_buf [PAYLOAD_CAP];
    int          msg_count   = 0;
    logic [7:0]  msg_sum     = '0;
    logic        msg_dropped = 1'b0;

    int error_count  = 0;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;

    api_tx_frame_builder_unit #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_message(i_end_of_message),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_byte    (o_frame_byte),
        .o_frame_end     (o_frame_end),
        .o_overflow      (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void due_byte(logic [7:0] b, logic last);
        t_frame_byte fb;
        fb.frame_byte = b;
        fb.frame_end  = last;
        fb.overflow   = msg_dropped;
        frame_bytes_due.push_back(fb);
    endfunction

    function automatic void assemble_frame(logic [7:0] b, logic end_mark);
        logic [7:0] csum;
        logic [7:0] len_lo;
        int k;
        if (msg_count < PAYLOAD_CAP) begin
            msg_buf[msg_count] = b;
            msg_count++;
            msg_sum = msg_sum + b;
        end else begin
            msg_dropped = 1'b1;
        end
        if (end_mark) begin
            csum = msg_sum + reg_api_id + reg_frame_num + reg_dest[15:8]
                   + reg_dest[7:0] + reg_options;
            len_lo = 8'(msg_count) + LEN_OVERHEAD;
            due_byte(reg_delim, 1'b0);
            due_byte(LEN_HI_BYTE, 1'b0);
            due_byte(len_lo, 1'b0);
            due_byte(reg_api_id, 1'b0);
            due_byte(reg_frame_num, 1'b0);
            due_byte(reg_dest[15:8], 1'b0);
            due_byte(reg_dest[7:0], 1'b0);
            due_byte(reg_options, 1'b0);
            for (k = 0; k < msg_count; k++) begin
                due_byte(msg_buf[k], 1'b0);
            end
            due_byte(CSUM_BASE - csum, 1'b1);
            msg_count   = 0;
            msg_sum     = '0;
            msg_dropped = 1'b0;
        end
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_START_DELIM: reg_delim     = data[7:0];
            CFG_API_ID:      reg_api_id    = data[7:0];
            CFG_FRAME_NUM:   reg_frame_num = data[7:0];
            CFG_DEST_ADDR:   reg_dest      = data[15:0];
            CFG_OPTIONS:     reg_options   = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void push_item(logic [7:0] b, logic end_mark, bit drain);
        t_msg_byte mb;
        mb.data_byte  = b;
        mb.end_mark   = end_mark;
        mb.wait_drain = drain;
        msg_bytes_pending.push_back(mb);
    endfunction

    function automatic int push_message(int len, bit ends, bit drain);
        int k;
        for (k = 0; k < len; k++) begin
            push_item(8'($urandom_range(0, 255)), ends && (k == len - 1), drain && (k == 0));
        end
        return len;
    endfunction

    function automatic void push_random_messages(int first_len);
        int n;
        int m;
        int len;
        n = push_message(first_len, 1'b1, 1'b0);
        m = 1;
        while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(30, PAYLOAD_CAP + 8);
            end else begin
                len = $urandom_range(1, 10);
            end
            n += push_message(len, 1'b1, (m == 1) || ($urandom_range(0, 7) == 0));
            m++;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    task automatic write_unused_reg();
        write_reg(CFG_IDX_W'($urandom_range(CFG_OPTIONS + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    task automatic wait_idle();
        while (msg_bytes_pending.size() > 0 || i_in_valid || frame_bytes_due.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_phase(int send_gap, int stall);
        @(negedge i_clk);
        send_gap_pct = send_gap;
        stall_pct    = stall;
    endtask

    // message byte driver
    always @(posedge i_clk) begin
        t_msg_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                assemble_frame(i_data_byte, i_end_of_message);
            end
            if (!i_in_valid || o_in_ready) begin
                if (msg_bytes_pending.size() > 0
                    && !(msg_bytes_pending[0].wait_drain && frame_bytes_due.size() > 0)
                    && $urandom_range(0, 99) >= send_gap_pct) begin
                    nxt = msg_bytes_pending.pop_front();
                    i_in_valid       <= 1'b1;
                    i_data_byte      <= nxt.data_byte;
                    i_end_of_message <= nxt.end_mark;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // frame byte monitor
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, actual byte %02h",
                             $time, o_frame_byte);
                    error_count++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (o_frame_byte !== want.frame_byte) begin
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, want.frame_byte, o_frame_byte);
                        error_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.frame_end, o_frame_end);
                        error_count++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, o_overflow);
                        error_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        start_phase(11, 66);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hA5, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        for (k = 0; k < 8; k++) begin
            push_item(8'h01 << k, k == 7, 1'b0);
        end
        wait_idle();

        write_reg(CFG_START_DELIM, 16'hFFFF);
        write_reg(CFG_API_ID, 16'hFFFF);
        write_reg(CFG_FRAME_NUM, 16'hFFFF);
        write_reg(CFG_DEST_ADDR, 16'hFFFF);
        write_reg(CFG_OPTIONS, 16'hFFFF);
        write_unused_reg();
        start_phase(11, 66);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'hC3, 1'b1, 1'b0);
        push_random_messages(PAYLOAD_CAP);
        // leave a message open across the register change
        void'(push_message(3, 1'b0, 1'b0));
        wait_idle();

        write_reg(CFG_START_DELIM, 16'h0000);
        write_reg(CFG_API_ID, 16'h0000);
        write_reg(CFG_FRAME_NUM, 16'h0000);
        write_reg(CFG_DEST_ADDR, 16'h0000);
        write_reg(CFG_OPTIONS, 16'h0000);
        write_unused_reg();
        start_phase(66, 11);
        push_random_messages(PAYLOAD_CAP + 1);
        wait_idle();

        write_reg(CFG_START_DELIM, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_API_ID, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_FRAME_NUM, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_DEST_ADDR, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_OPTIONS, CFG_DATA_W'($urandom_range(0, 65535)));
        write_unused_reg();
        start_phase(0, 0);
        push_random_messages($urandom_range(PAYLOAD_CAP + 2, PAYLOAD_CAP + 8));

        while (msg_bytes_pending.size() > 0 || i_in_valid || frame_bytes_due.size() > 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
